@@ rtl/core/fcw_pkg.sv @@
`timescale 1ns / 1ps

package fcw_pkg;

   // command codes of the request channel
   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_START   = 2'd1,
      CMD_ADVANCE = 2'd2
   } cmd_type;

   // status codes of the response channel
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_PAST_END = 2'd1,
      STAT_LOW      = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic REG_DATA_FIRST = 1'b0;
   localparam logic REG_SPC        = 1'b1;

   localparam logic [11:0] END_MARK    = 12'hFFF;
   localparam logic [7:0]  LOW_NIBBLE  = 8'h0F;
   localparam logic [7:0]  HIGH_NIBBLE = 8'hF0;
   localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

   typedef struct packed {
      cmd_type     cmd;
      logic [12:0] table_offset;
      logic [7:0]  table_byte;
      logic [11:0] start_cluster;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] cluster;
      logic [15:0] first_sector;
      logic        last;
      status_type  status;
   } rsp_payload_type;

   // how the two bytes of one table lookup are to be combined
   typedef struct packed {
      logic odd;
      logic ok_lo;
      logic ok_hi;
   } lookup_type;

   // byte offset of a 12-bit entry: cluster * 3 / 2
   function automatic logic [12:0] entry_offset(input logic [11:0] clu);
      entry_offset = {1'b0, clu} + {2'b00, clu[11:1]};
   endfunction

endpackage

@@ rtl/core/fcw_ram.sv @@
`timescale 1ns / 1ps

module fcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // one write port, two registered read ports that hold when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/core/fcw_entry.sv @@
`timescale 1ns / 1ps

module fcw_entry import fcw_pkg::*; (
   input  logic [7:0]  byte_lo,
   input  logic [7:0]  byte_hi,
   input  lookup_type  lookup,
   output logic [11:0] entry
);

   logic [7:0] b0;
   logic [7:0] b1;

   // bytes past the end of the table read as zero
   assign b0 = lookup.ok_lo ? byte_lo : 8'h00;
   assign b1 = lookup.ok_hi ? byte_hi : 8'h00;

   // even cluster: low byte plus low nibble of next; odd: high nibble plus next byte
   always_comb begin
      if (lookup.odd) begin
         entry = {b1, 4'((b0 & HIGH_NIBBLE) >> 4)};
      end else begin
         entry = {4'(b1 & LOW_NIBBLE), b0};
      end
   end

endmodule

@@ rtl/core/fcw_sector.sv @@
`timescale 1ns / 1ps

module fcw_sector (
   input  logic [11:0] cluster,
   input  logic [15:0] data_first,
   input  logic [7:0]  sectors_per_cluster,
   output logic [15:0] first_sector
);

   logic [15:0] rel_cluster;
   logic [23:0] product;

   // (cluster - 2) wraps at 16 bits, the sum too
   assign rel_cluster  = {4'b0000, cluster} - 16'd2;
   assign product      = rel_cluster * sectors_per_cluster;
   assign first_sector = data_first + product[15:0];

endmodule

@@ rtl/core/fat12_cluster_chain_walker.sv @@
`timescale 1ns / 1ps
// load: one transfer per cycle, no response.
// start: the landing step registers the response once the response register is free.
// advance: hop step, then landing (landing at once when the chain has ended); each lookup
// reads both table bytes at once; a stalled response holds landing; requests wait until idle.
// reset is synchronous: clears control state and configuration to defaults;
// the table is undefined until loaded and gets no clearing pass.
module fat12_cluster_chain_walker import fcw_pkg::*; #(
   parameter int TABLE_BYTES = 8192
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic            csr_index,
   input  logic [15:0]     csr_wr_data
);

   localparam int AW = $clog2(TABLE_BYTES);
   localparam logic [13:0] TABLE_LIMIT = 14'(TABLE_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HOP,
      ST_LAND
   } state_type;

   state_type       state_ff;
   logic [11:0]     cur_ff;
   logic            ended_ff;
   logic            past_end_ff;
   lookup_type      lookup_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic [15:0]     data_first_ff;
   logic [7:0]      spc_ff;

   logic            req_fire;
   logic            rsp_free;
   logic [11:0]     look_clu;
   logic [12:0]     look_off;
   logic [12:0]     look_off_hi;
   lookup_type      lookup_in;
   logic            rd_en;
   logic            wr_en;
   logic [7:0]      rd_lo;
   logic [7:0]      rd_hi;
   logic [11:0]     entry;
   logic [15:0]     first_sector;
   logic            land_last;
   logic            land_low;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // cluster whose entry is looked up next
   always_comb begin
      if (state_ff == ST_HOP) begin
         look_clu = entry;
      end else if (req_data.cmd == CMD_START) begin
         look_clu = req_data.start_cluster;
      end else begin
         look_clu = cur_ff;
      end
   end

   assign look_off        = entry_offset(look_clu);
   assign look_off_hi     = look_off + 13'd1;
   assign lookup_in.odd   = look_clu[0];
   assign lookup_in.ok_lo = {1'b0, look_off} < TABLE_LIMIT;
   assign lookup_in.ok_hi = {1'b0, look_off_hi} < TABLE_LIMIT;

   // memory ports: loads write, start/advance/hop read both entry bytes
   assign rd_en = (state_ff == ST_HOP) ||
                  (req_fire && (req_data.cmd == CMD_START || req_data.cmd == CMD_ADVANCE));
   assign wr_en = req_fire && (req_data.cmd == CMD_LOAD) &&
                  ({1'b0, req_data.table_offset} < TABLE_LIMIT);

   fcw_ram #(
      .WIDTH(8),
      .DEPTH(TABLE_BYTES)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_data.table_offset[AW-1:0]),
      .wr_data   (req_data.table_byte),
      .rd_en     (rd_en),
      .rd_addr_a (look_off[AW-1:0]),
      .rd_addr_b (look_off_hi[AW-1:0]),
      .rd_data_a (rd_lo),
      .rd_data_b (rd_hi)
   );

   fcw_entry u_entry (
      .byte_lo (rd_lo),
      .byte_hi (rd_hi),
      .lookup  (lookup_ff),
      .entry   (entry)
   );

   fcw_sector u_sector (
      .cluster             (cur_ff),
      .data_first          (data_first_ff),
      .sectors_per_cluster (spc_ff),
      .first_sector        (first_sector)
   );

   assign land_last = (entry == END_MARK);
   assign land_low  = (cur_ff < FIRST_DATA_CLUSTER);

   // sequencer, chain state, configuration and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_ff        <= '0;
         ended_ff      <= 1'b1;
         past_end_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         data_first_ff <= '0;
         spc_ff        <= 8'd1;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_DATA_FIRST: data_first_ff <= csr_wr_data;
               REG_SPC:        spc_ff        <= csr_wr_data[7:0];
               default: ;
            endcase
         end
         // a taken response leaves unless the landing step refills it
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_LAND)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_data.cmd)
                     CMD_START: begin
                        cur_ff      <= req_data.start_cluster;
                        past_end_ff <= 1'b0;
                        lookup_ff   <= lookup_in;
                        state_ff    <= ST_LAND;
                     end
                     CMD_ADVANCE: begin
                        lookup_ff   <= lookup_in;
                        past_end_ff <= ended_ff;
                        state_ff    <= ended_ff ? ST_LAND : ST_HOP;
                     end
                     default: ;
                  endcase
               end
            end
            ST_HOP: begin
               cur_ff    <= entry;
               lookup_ff <= lookup_in;
               state_ff  <= ST_LAND;
            end
            ST_LAND: begin
               if (rsp_free) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.cluster       <= cur_ff;
                  rsp_data_ff.first_sector  <= first_sector;
                  rsp_data_ff.last          <= land_last;
                  if (past_end_ff) begin
                     rsp_data_ff.status <= STAT_PAST_END;
                  end else begin
                     rsp_data_ff.status <= land_low ? STAT_LOW : STAT_OK;
                     ended_ff           <= land_low || land_last;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/fcw_checker.sv @@
`timescale 1ns / 1ps

module fcw_checker import fcw_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // start and advance keep the request side busy while the lookup runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.cmd == CMD_START || req_data.cmd == CMD_ADVANCE) |=> req_stall)
      else $error("request taken during a lookup");

   // a load completes in the cycle of its transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_LOAD |=> !req_stall)
      else $error("load left the block busy");

   // low-cluster status matches the reported cluster
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_PAST_END |->
      ((rsp_data.status == STAT_LOW) == (rsp_data.cluster < FIRST_DATA_CLUSTER)))
      else $error("status does not match cluster");

   // no response right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import fcw_pkg::*;

   localparam int TABLE_BYTES = 8192;
   localparam int PHASE_ITEMS = 72;
   localparam int PHASES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam cmd_type CMD_UNUSED = cmd_type'(2'd3);

   // tracks the allocation table, the walk position and the results still owed
   class chain_walk_tracker;
      logic [7:0]      fat_bytes [TABLE_BYTES];
      bit              loaded [TABLE_BYTES];
      logic [11:0]     cur_cluster;
      bit              chain_done;
      logic [15:0]     data_first;
      logic [7:0]      spc;
      rsp_payload_type owed_results[$];
      int              errors;

      function new();
         foreach (loaded[i]) begin
            loaded[i] = 1'b0;
            fat_bytes[i] = 8'h00;
         end
         cur_cluster = 12'd0;
         chain_done = 1'b1;
         data_first = 16'd0;
         spc = 8'd1;
         errors = 0;
      endfunction

      task report_mismatch(input string what);
         $display("%0t ns: mismatch: %s", $time, what);
         errors++;
      endtask

      function logic [7:0] byte_at(input int off);
         if (off >= TABLE_BYTES || !loaded[off]) return 8'h00;
         return fat_bytes[off];
      endfunction

      // 12-bit entry packed at byte offset cluster * 3 / 2
      function logic [11:0] entry_value(input logic [11:0] clu);
         int         off;
         logic [7:0] b0;
         logic [7:0] b1;
         off = int'(clu) + int'(clu >> 1);
         b0 = byte_at(off);
         b1 = byte_at(off + 1);
         if (!clu[0]) return {b1[3:0], b0};
         return {b1, b0[7:4]};
      endfunction

      function bit entry_ready(input logic [11:0] clu);
         int off;
         off = int'(clu) + int'(clu >> 1);
         return loaded[off] && (off + 1 >= TABLE_BYTES || loaded[off + 1]);
      endfunction

      // an advance must not touch a table byte that was never loaded
      function bit advance_ready();
         if (chain_done) return entry_ready(cur_cluster);
         return entry_ready(entry_value(cur_cluster));
      endfunction

      function logic [15:0] sector_of(input logic [11:0] clu);
         logic [15:0] rel;
         rel = {4'd0, clu} - 16'd2;
         return data_first + rel * {8'd0, spc};
      endfunction

      function void owe_result(input status_type st);
         rsp_payload_type r;
         r.cluster = cur_cluster;
         r.first_sector = sector_of(cur_cluster);
         r.last = (entry_value(cur_cluster) == END_MARK);
         r.status = st;
         owed_results.push_back(r);
      endfunction

      function void land_on_cluster();
         bit low;
         low = (cur_cluster < FIRST_DATA_CLUSTER);
         chain_done = low || (entry_value(cur_cluster) == END_MARK);
         owe_result(low ? STAT_LOW : STAT_OK);
      endfunction

      function void write_register(input logic idx, input logic [15:0] val);
         if (idx == REG_DATA_FIRST) data_first = val;
         else spc = val[7:0];
      endfunction

      function void track_request(input req_payload_type rq);
         case (rq.cmd)
            CMD_LOAD: begin
               fat_bytes[rq.table_offset] = rq.table_byte;
               loaded[rq.table_offset] = 1'b1;
            end
            CMD_START: begin
               cur_cluster = rq.start_cluster;
               land_on_cluster();
            end
            CMD_ADVANCE: begin
               if (chain_done) owe_result(STAT_PAST_END);
               else begin
                  cur_cluster = entry_value(cur_cluster);
                  land_on_cluster();
               end
            end
            default: ;
         endcase
      endfunction

      task check_cluster_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result with none owed: cluster 0x%0h", got.cluster));
         end else begin
            want = owed_results.pop_front();
            if (got.cluster !== want.cluster)
               report_mismatch($sformatf("cluster got 0x%0h want 0x%0h",
                                         got.cluster, want.cluster));
            if (got.first_sector !== want.first_sector)
               report_mismatch($sformatf("first_sector got 0x%0h want 0x%0h (cluster 0x%0h)",
                                         got.first_sector, want.first_sector, want.cluster));
            if (got.last !== want.last)
               report_mismatch($sformatf("last got %0b want %0b (cluster 0x%0h)",
                                         got.last, want.last, want.cluster));
            if (got.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d (cluster 0x%0h)",
                                         got.status, want.status, want.cluster));
         end
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_wr_en;
   logic            csr_index;
   logic [15:0]     csr_wr_data;

   chain_walk_tracker walker;
   bit                idle_on = 1'b0;
   int                stall_left = 0;
   int                items_sent = 0;
   logic [11:0]       known_clusters[$];

   fat12_cluster_chain_walker #(.TABLE_BYTES(TABLE_BYTES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watch transfers and register writes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) walker.track_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            walker.check_cluster_result(rsp_data);
            stall_left = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (csr_wr_en) walker.write_register(csr_index, csr_wr_data);
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
   end

   function automatic req_payload_type junk_item();
      req_payload_type it;
      it.cmd = cmd_type'($urandom_range(0, 3));
      it.table_offset = 13'($urandom);
      it.table_byte = 8'($urandom);
      it.start_cluster = 12'($urandom);
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_request(input req_payload_type item);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (item.cmd != CMD_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   task automatic load_byte(input int off, input logic [7:0] val);
      req_payload_type it;
      it = junk_item();
      it.cmd = CMD_LOAD;
      it.table_offset = 13'(off);
      it.table_byte = val;
      send_request(it);
   endtask

   task automatic start_chain(input logic [11:0] clu);
      req_payload_type it;
      it = junk_item();
      it.cmd = CMD_START;
      it.start_cluster = clu;
      send_request(it);
   endtask

   task automatic advance_chain();
      req_payload_type it;
      it = junk_item();
      it.cmd = CMD_ADVANCE;
      send_request(it);
   endtask

   task automatic send_unused();
      req_payload_type it;
      it = junk_item();
      it.cmd = CMD_UNUSED;
      send_request(it);
   endtask

   // write one 12-bit entry with two byte loads, keeping the neighbor's nibble
   task automatic put_entry(input logic [11:0] clu, input logic [11:0] val);
      int         off;
      logic [7:0] b0;
      logic [7:0] b1;
      off = int'(clu) + int'(clu >> 1);
      b0 = walker.loaded[off] ? walker.fat_bytes[off] : 8'($urandom);
      b1 = walker.loaded[off + 1] ? walker.fat_bytes[off + 1] : 8'($urandom);
      if (!clu[0]) begin
         b0 = val[7:0];
         b1 = {b1[7:4], val[11:8]};
      end else begin
         b0 = {val[3:0], b0[3:0]};
         b1 = val[11:4];
      end
      load_byte(off, b0);
      load_byte(off + 1, b1);
   endtask

   // build a chain in the table, then walk it and a bit past its end
   task automatic run_chain();
      int          len;
      int          k;
      logic [11:0] links[$];
      logic [11:0] tail;
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) links.push_back(12'($urandom_range(2, 4095)));
      case ($urandom_range(0, 9))
         0: tail = 12'($urandom_range(0, 1));
         1: tail = links[$urandom_range(0, len - 1)];
         default: tail = END_MARK;
      endcase
      for (k = 0; k < len - 1; k++) put_entry(links[k], links[k + 1]);
      put_entry(links[len - 1], tail);
      for (k = 0; k < len; k++) known_clusters.push_back(links[k]);
      // now and then join the chain in the middle
      if ($urandom_range(0, 6) == 0) start_chain(links[$urandom_range(0, len - 1)]);
      else start_chain(links[0]);
      repeat (len + $urandom_range(0, 2)) begin
         if (walker.advance_ready()) advance_chain();
      end
   endtask

   task automatic send_noise();
      int          pick;
      logic [11:0] clu;
      pick = $urandom_range(0, 3);
      if (known_clusters.size() > 0 && $urandom_range(0, 1) == 1)
         clu = known_clusters[$urandom_range(0, known_clusters.size() - 1)];
      else
         clu = 12'($urandom);
      if (pick == 1 && walker.entry_ready(clu)) start_chain(clu);
      else if (pick == 2 && walker.advance_ready()) advance_chain();
      else if (pick == 3) send_unused();
      else load_byte($urandom_range(0, TABLE_BYTES - 1), 8'($urandom));
   endtask

   // wait for every owed result, then let any load in flight settle
   task automatic drain();
      req_valid <= 1'b0;
      while (walker.owed_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_registers(input logic [15:0] first_sec, input logic [15:0] spc_word);
      csr_wr_en <= 1'b1;
      csr_index <= REG_DATA_FIRST;
      csr_wr_data <= first_sec;
      @(negedge clock);
      csr_index <= REG_SPC;
      csr_wr_data <= spc_word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      int p;
      int phase_start;
      walker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = REG_DATA_FIRST;
      csr_wr_data = 16'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // entries of clusters 0 and 1: 0xFF0 and the end mark
      idle_on = 1'b1;
      load_byte(0, 8'hF0);
      load_byte(1, 8'hFF);
      load_byte(2, 8'hFF);
      // advance with no chain active, then clusters below 2
      advance_chain();
      start_chain(12'd0);
      start_chain(12'd1);
      advance_chain();
      // top table byte, offset bit 12, unused command
      load_byte(TABLE_BYTES - 1, 8'h00);
      load_byte(4096, 8'hFF);
      send_unused();
      // even and odd entries up to the highest cluster numbers
      put_entry(12'd2, 12'd3);
      put_entry(12'd3, 12'd4094);
      put_entry(12'd4094, END_MARK);
      start_chain(12'd2);
      repeat (3) advance_chain();
      // walk from the top cluster down to cluster 0
      put_entry(12'd4095, 12'd0);
      start_chain(12'd4095);
      repeat (2) advance_chain();

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               1: write_registers(16'hFFFF, 16'd128);
               2: write_registers(16'h0000, 16'h0000);
               3: write_registers(16'($urandom), {8'($urandom), 8'hFF});
               4: write_registers(16'($urandom), {8'($urandom), 8'($urandom_range(1, 128))});
               default: write_registers(16'($urandom), 16'd1);
            endcase
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0) run_chain();
            else repeat ($urandom_range(1, 3)) send_noise();
         end
      end

      drain();
      if (walker.errors == 0 && walker.owed_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
